[src/brvx_pkg.sv]
// Shared types, constants and tag table for the BER response value extractor.
package brvx_pkg;

  localparam int RX_BUFFER_BYTES = 512;
  localparam int MAX_OID_BYTES   = 16;
  localparam int POS_W           = $clog2(RX_BUFFER_BYTES + 1);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] TAG_OCTETS   = 8'h04;
  localparam logic [7:0] TAG_OID      = 8'h06;
  localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;
  localparam logic [7:0] LEN_LONG_MIN   = 8'd128;

  localparam logic [1:0] CFG_OID_LENGTH = 2'd0;
  localparam logic [1:0] CFG_OID_HEAD   = 2'd1;
  localparam logic [1:0] CFG_OID_TAIL   = 2'd2;

  localparam logic [3:0] EL_SEQUENCE  = 4'd0;
  localparam logic [3:0] EL_VERSION   = 4'd1;
  localparam logic [3:0] EL_COMMUNITY = 4'd2;
  localparam logic [3:0] EL_PDU       = 4'd3;
  localparam logic [3:0] EL_REQ_ID    = 4'd4;
  localparam logic [3:0] EL_ERR_STAT  = 4'd5;
  localparam logic [3:0] EL_ERR_IDX   = 4'd6;
  localparam logic [3:0] EL_VB_LIST   = 4'd7;
  localparam logic [3:0] EL_VARBIND   = 4'd8;
  localparam logic [3:0] EL_OID       = 4'd9;
  localparam logic [3:0] EL_VALUE     = 4'd10;

  typedef enum logic [2:0] {
    PH_TAG, PH_LEN_FIRST, PH_LEN_MORE, PH_SKIP, PH_OID, PH_VALUE, PH_DONE, PH_BAD
  } phase_t;

  typedef enum logic [2:0] {
    OC_FOUND     = 3'd0,
    OC_BAD_TAG   = 3'd1,
    OC_TRUNCATED = 3'd2,
    OC_MISMATCH  = 3'd3,
    OC_OVERRUN   = 3'd4
  } outcome_t;

  typedef enum logic {
    KIND_VALUE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic [4:0]  oid_length;
    logic [63:0] oid_head;
    logic [63:0] oid_tail;
  } cfg_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  value_byte;
    outcome_t    outcome;
    logic [7:0]  found_tag;
    logic [15:0] found_length;
    logic [31:0] counter_value;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // bit 8 set: any tag accepted
  function automatic logic [8:0] expected_tag(input logic [3:0] el);
    case (el)
      EL_SEQUENCE:  expected_tag = {1'b0, TAG_SEQUENCE};
      EL_VERSION:   expected_tag = {1'b0, TAG_INTEGER};
      EL_COMMUNITY: expected_tag = {1'b0, TAG_OCTETS};
      EL_REQ_ID:    expected_tag = {1'b0, TAG_INTEGER};
      EL_ERR_STAT:  expected_tag = {1'b0, TAG_INTEGER};
      EL_ERR_IDX:   expected_tag = {1'b0, TAG_INTEGER};
      EL_VB_LIST:   expected_tag = {1'b0, TAG_SEQUENCE};
      EL_VARBIND:   expected_tag = {1'b0, TAG_SEQUENCE};
      EL_OID:       expected_tag = {1'b0, TAG_OID};
      default:      expected_tag = 9'h100;
    endcase
  endfunction

endpackage

[src/ber_response_value_extractor_core.sv]
// Top level of the BER response value extractor: config registers, parser, result queue.
//
//  channel | direction | ports                                   | request
//  in      | sink      | in_message_byte, in_final_byte          | one message byte
//  out     | source    | out_item_kind .. out_run_end            | one result item
//  cfg     | sink      | cfg_index, cfg_data                     | one register write
//
//  A byte is taken per cycle while in_ready is high; its results are queued at that edge.
//  A byte yields at most two items (value byte, then status on the final byte).
//  in_ready drops while the four-entry queue has fewer than two free slots.
//  cfg_ready is always high. Reset is synchronous and clears all parse state.
module ber_response_value_extractor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_message_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_value_byte,
  output logic [2:0]  out_outcome,
  output logic [7:0]  out_found_tag,
  output logic [15:0] out_found_length,
  output logic [31:0] out_counter_value,
  output logic        out_run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import brvx_pkg::*;

  cfg_t      cfg_r;
  push_t     push;
  out_item_t item;
  logic      accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oid_length <= 5'd8;
      cfg_r.oid_head   <= 64'd0;
      cfg_r.oid_tail   <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OID_LENGTH: cfg_r.oid_length <= cfg_data[4:0];
        CFG_OID_HEAD:   cfg_r.oid_head   <= cfg_data;
        CFG_OID_TAIL:   cfg_r.oid_tail   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  brvx_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .msg_byte (in_message_byte),
    .fin      (in_final_byte),
    .cfg      (cfg_r),
    .push     (push)
  );

  brvx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (item)
  );

  assign out_item_kind     = item.item_kind;
  assign out_value_byte    = item.value_byte;
  assign out_outcome       = item.outcome;
  assign out_found_tag     = item.found_tag;
  assign out_found_length  = item.found_length;
  assign out_counter_value = item.counter_value;
  assign out_run_end       = item.run_end;

endmodule

[src/brvx_parser.sv]
// Header walker, OID compare and value extraction for one message byte per request.
module brvx_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      msg_byte,
  input  logic            fin,
  input  brvx_pkg::cfg_t  cfg,
  output brvx_pkg::push_t push
);
  import brvx_pkg::*;

  phase_t      phase_r,   phase_nxt;
  logic [3:0]  elem_r,    elem_nxt;
  logic [15:0] lacc_r,    lacc_nxt;
  logic [6:0]  lleft_r,   lleft_nxt;
  logic [15:0] skip_r,    skip_nxt;
  logic [4:0]  oidx_r,    oidx_nxt;
  logic        match_r,   match_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  htag_r,    htag_nxt;
  logic [15:0] hlen_r,    hlen_nxt;
  logic [15:0] seen_r,    seen_nxt;
  logic [31:0] cnt_r,     cnt_nxt;
  outcome_t    pend_r,    pend_nxt;

  logic        ld;
  logic [15:0] ld_len;
  logic        emit;
  logic [8:0]  exp_tag;
  logic [7:0]  tgt_byte;
  logic [127:0] tgt_all;
  out_item_t   vitem, sitem;

  always_comb begin
    phase_nxt = phase_r;
    elem_nxt  = elem_r;
    lacc_nxt  = lacc_r;
    lleft_nxt = lleft_r;
    skip_nxt  = skip_r;
    oidx_nxt  = oidx_r;
    match_nxt = match_r;
    pos_nxt   = pos_r;
    htag_nxt  = htag_r;
    hlen_nxt  = hlen_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    ld        = 1'b0;
    ld_len    = 16'd0;
    emit      = 1'b0;
    exp_tag   = expected_tag(elem_r);
    tgt_all   = {cfg.oid_head, cfg.oid_tail};
    tgt_byte  = tgt_all[8'd127 - {oidx_r[3:0], 3'd0} -: 8];

    if (accept && (pos_r < POS_W'(RX_BUFFER_BYTES))) begin
      pos_nxt = pos_r + POS_W'(1);
      case (phase_r)
        PH_TAG: begin
          if (elem_r > EL_VALUE) begin
            phase_nxt = PH_DONE;
          end else if (!exp_tag[8] && (exp_tag[7:0] != msg_byte)) begin
            pend_nxt  = OC_BAD_TAG;
            phase_nxt = PH_BAD;
          end else begin
            if (elem_r == EL_VALUE) htag_nxt = msg_byte;
            phase_nxt = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (msg_byte < LEN_LONG_MIN) begin
            ld     = 1'b1;
            ld_len = {8'd0, msg_byte};
          end else begin
            lleft_nxt = msg_byte[6:0] & LEN_COUNT_MASK[6:0];
            lacc_nxt  = 16'd0;
            if (lleft_nxt == 7'd0) ld = 1'b1;
            else phase_nxt = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          if (lacc_r > 16'h00FF) lacc_nxt = 16'hFFFF;
          else lacc_nxt = {lacc_r[7:0], msg_byte};
          lleft_nxt = lleft_r - 7'd1;
          if (lleft_nxt == 7'd0) begin
            ld     = 1'b1;
            ld_len = lacc_nxt;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_nxt == 16'd0) begin
            elem_nxt  = elem_r + 4'd1;
            phase_nxt = PH_TAG;
          end
        end
        PH_OID: begin
          if (match_r && ((oidx_r >= 5'(MAX_OID_BYTES)) || (tgt_byte != msg_byte)))
            match_nxt = 1'b0;
          if (oidx_r < 5'd31) oidx_nxt = oidx_r + 5'd1;
          skip_nxt = skip_r - 16'd1;
          if (skip_nxt == 16'd0) begin
            elem_nxt  = elem_r + 4'd1;
            phase_nxt = PH_TAG;
          end
        end
        PH_VALUE: begin
          seen_nxt = seen_r + 16'd1;
          if (seen_nxt >= hlen_r) begin
            phase_nxt = PH_DONE;
            if (match_r) pend_nxt = OC_FOUND;
          end
          if (match_r) begin
            cnt_nxt = {cnt_r[23:0], msg_byte};
            emit    = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (ld) begin
        case (elem_r)
          EL_VERSION, EL_COMMUNITY, EL_REQ_ID, EL_ERR_STAT, EL_ERR_IDX: begin
            if (ld_len == 16'd0) begin
              elem_nxt  = elem_r + 4'd1;
              phase_nxt = PH_TAG;
            end else begin
              skip_nxt  = ld_len;
              phase_nxt = PH_SKIP;
            end
          end
          EL_OID: begin
            match_nxt = (ld_len == {11'd0, cfg.oid_length}) &&
                        (cfg.oid_length <= 5'(MAX_OID_BYTES));
            oidx_nxt  = 5'd0;
            if (ld_len == 16'd0) begin
              elem_nxt  = elem_r + 4'd1;
              phase_nxt = PH_TAG;
            end else begin
              skip_nxt  = ld_len;
              phase_nxt = PH_OID;
            end
          end
          EL_VALUE: begin
            hlen_nxt = ld_len;
            seen_nxt = 16'd0;
            cnt_nxt  = 32'd0;
            if (!match_r) pend_nxt = OC_MISMATCH;
            else pend_nxt = (ld_len == 16'd0) ? OC_FOUND : OC_OVERRUN;
            phase_nxt = (ld_len == 16'd0) ? PH_DONE : PH_VALUE;
          end
          default: begin
            elem_nxt  = elem_r + 4'd1;
            phase_nxt = PH_TAG;
          end
        endcase
      end
    end

    vitem = '{item_kind: KIND_VALUE, value_byte: msg_byte, outcome: OC_FOUND,
              found_tag: 8'd0, found_length: 16'd0, counter_value: 32'd0, run_end: 1'b0};
    sitem = '{item_kind: KIND_STATUS, value_byte: 8'd0, outcome: pend_nxt,
              found_tag: htag_nxt, found_length: hlen_nxt, counter_value: cnt_nxt,
              run_end: 1'b1};

    push.count  = {1'b0, emit} + {1'b0, accept && fin};
    push.first  = emit ? vitem : sitem;
    push.second = sitem;

    if (accept && fin) begin
      phase_nxt = PH_TAG;
      elem_nxt  = EL_SEQUENCE;
      lacc_nxt  = 16'd0;
      lleft_nxt = 7'd0;
      skip_nxt  = 16'd0;
      oidx_nxt  = 5'd0;
      match_nxt = 1'b1;
      pos_nxt   = '0;
      htag_nxt  = 8'd0;
      hlen_nxt  = 16'd0;
      seen_nxt  = 16'd0;
      cnt_nxt   = 32'd0;
      pend_nxt  = OC_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      elem_r  <= EL_SEQUENCE;
      lacc_r  <= 16'd0;
      lleft_r <= 7'd0;
      skip_r  <= 16'd0;
      oidx_r  <= 5'd0;
      match_r <= 1'b1;
      pos_r   <= '0;
      htag_r  <= 8'd0;
      hlen_r  <= 16'd0;
      seen_r  <= 16'd0;
      cnt_r   <= 32'd0;
      pend_r  <= OC_TRUNCATED;
    end else begin
      phase_r <= phase_nxt;
      elem_r  <= elem_nxt;
      lacc_r  <= lacc_nxt;
      lleft_r <= lleft_nxt;
      skip_r  <= skip_nxt;
      oidx_r  <= oidx_nxt;
      match_r <= match_nxt;
      pos_r   <= pos_nxt;
      htag_r  <= htag_nxt;
      hlen_r  <= hlen_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_fin_pushes_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fin) |-> (push.count != 2'd0))
    else $error("final byte without status item");

  a_fin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fin) |=> (phase_r == PH_TAG && elem_r == EL_SEQUENCE && pos_r == '0))
    else $error("parser not restarted after final byte");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(RX_BUFFER_BYTES))
    else $error("byte position past buffer");

endmodule

[src/brvx_outq.sv]
// Result queue: takes up to two result items per cycle, delivers one per cycle while out_ready is high.
module brvx_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  brvx_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output brvx_pkg::out_item_t out_item
);
  import brvx_pkg::*;

  out_item_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic              pop;

  assign room      = count_r <= QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_item  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entry_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) entry_r[wr_ptr_r + QPTR_W'(1)] <= push.second;
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> (count_r <= QCNT_W'(QUEUE_DEPTH - 2)))
    else $error("push into queue without room");

endmodule

[verif/ber_response_value_extractor_core_tb.sv]
// Testbench for ber_response_value_extractor_core: random SNMP frames checked against a predictor.
module ber_response_value_extractor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brvx_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_byte_t;

  typedef enum int {
    FR_WHOLE, FR_CUT, FR_BAD_TAG, FR_SHORT_VALUE, FR_NOISE
  } frame_shape_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_message_byte = '0;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_value_byte;
  logic [2:0]  out_outcome;
  logic [7:0]  out_found_tag;
  logic [15:0] out_found_length;
  logic [31:0] out_counter_value;
  logic        out_run_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  ber_response_value_extractor_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_byte   (in_message_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_value_byte    (out_value_byte),
    .out_outcome       (out_outcome),
    .out_found_tag     (out_found_tag),
    .out_found_length  (out_found_length),
    .out_counter_value (out_counter_value),
    .out_run_end       (out_run_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  rx_byte_t   rx_pending[$];
  out_item_t  awaited[$];
  logic [7:0] frame[$];
  int         tag_spots[$];
  int         value_hdr_end;
  int         value_end;

  bit in_bursts;
  bit out_bursts;
  int in_gap;
  int out_gap;
  int error_count;
  int frames_sent;
  int bytes_taken;
  int value_items;
  int status_items;
  int outcome_seen[5];

  // parser mirror
  cfg_t        tgt;
  phase_t      ph;
  logic [3:0]  elem;
  logic [15:0] len_acc;
  logic [6:0]  len_left;
  logic [15:0] skip_cnt;
  logic [4:0]  oid_idx;
  logic        oid_ok;
  logic [9:0]  pos;
  logic [7:0]  tag_hold;
  logic [15:0] len_hold;
  logic [15:0] val_seen;
  logic [31:0] ctr;
  outcome_t    verdict;

  task automatic clear_parse();
    ph       = PH_TAG;
    elem     = EL_SEQUENCE;
    len_acc  = '0;
    len_left = '0;
    skip_cnt = '0;
    oid_idx  = '0;
    oid_ok   = 1'b1;
    pos      = '0;
    tag_hold = '0;
    len_hold = '0;
    val_seen = '0;
    ctr      = '0;
    verdict  = OC_TRUNCATED;
  endtask

  function automatic logic [7:0] target_octet(input logic [3:0] i);
    logic [63:0] w;
    w = i[3] ? tgt.oid_tail : tgt.oid_head;
    return w[63 - 8 * i[2:0] -: 8];
  endfunction

  task automatic advance_element();
    elem = elem + 4'd1;
    ph   = PH_TAG;
  endtask

  task automatic close_length(input logic [15:0] n);
    case (elem)
      EL_VERSION, EL_COMMUNITY, EL_REQ_ID, EL_ERR_STAT, EL_ERR_IDX: begin
        if (n == 0) begin
          advance_element();
        end else begin
          skip_cnt = n;
          ph       = PH_SKIP;
        end
      end
      EL_OID: begin
        oid_ok  = (n == {11'd0, tgt.oid_length}) && (tgt.oid_length <= MAX_OID_BYTES);
        oid_idx = '0;
        if (n == 0) begin
          advance_element();
        end else begin
          skip_cnt = n;
          ph       = PH_OID;
        end
      end
      EL_VALUE: begin
        len_hold = n;
        val_seen = '0;
        ctr      = '0;
        if (!oid_ok) verdict = OC_MISMATCH;
        else verdict = (n == 0) ? OC_FOUND : OC_OVERRUN;
        ph = (n == 0) ? PH_DONE : PH_VALUE;
      end
      default: advance_element();
    endcase
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic fin);
    out_item_t  r;
    logic [7:0] want_tag;
    logic       any_tag;
    if (pos < RX_BUFFER_BYTES) begin
      pos = pos + 10'd1;
      case (ph)
        PH_TAG: begin
          any_tag  = 1'b0;
          want_tag = TAG_SEQUENCE;
          case (elem)
            EL_VERSION, EL_REQ_ID, EL_ERR_STAT, EL_ERR_IDX: want_tag = TAG_INTEGER;
            EL_COMMUNITY: want_tag = TAG_OCTETS;
            EL_OID:       want_tag = TAG_OID;
            EL_PDU, EL_VALUE: any_tag = 1'b1;
            default: ;
          endcase
          if (elem > EL_VALUE) begin
            ph = PH_DONE;
          end else if (!any_tag && want_tag != b) begin
            verdict = OC_BAD_TAG;
            ph      = PH_BAD;
          end else begin
            if (elem == EL_VALUE) tag_hold = b;
            ph = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (b < LEN_LONG_MIN) begin
            close_length({8'h00, b});
          end else begin
            len_left = 7'(b & LEN_COUNT_MASK);
            len_acc  = '0;
            if (len_left == 0) close_length(16'd0);
            else ph = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          len_acc  = (len_acc > 16'h00FF) ? 16'hFFFF : {len_acc[7:0], b};
          len_left = len_left - 7'd1;
          if (len_left == 0) close_length(len_acc);
        end
        PH_SKIP: begin
          skip_cnt = skip_cnt - 16'd1;
          if (skip_cnt == 0) advance_element();
        end
        PH_OID: begin
          if (oid_ok && (oid_idx >= MAX_OID_BYTES || target_octet(oid_idx[3:0]) != b))
            oid_ok = 1'b0;
          if (oid_idx < 5'd31) oid_idx = oid_idx + 5'd1;
          skip_cnt = skip_cnt - 16'd1;
          if (skip_cnt == 0) advance_element();
        end
        PH_VALUE: begin
          val_seen = val_seen + 16'd1;
          if (val_seen >= len_hold) begin
            ph = PH_DONE;
            if (oid_ok) verdict = OC_FOUND;
          end
          if (oid_ok) begin
            ctr          = {ctr[23:0], b};
            r            = '0;
            r.item_kind  = KIND_VALUE;
            r.value_byte = b;
            r.outcome    = OC_FOUND;
            awaited.push_back(r);
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      r               = '0;
      r.item_kind     = KIND_STATUS;
      r.outcome       = verdict;
      r.found_tag     = tag_hold;
      r.found_length  = len_hold;
      r.counter_value = ctr;
      r.run_end       = 1'b1;
      awaited.push_back(r);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin : rx_drive
    rx_byte_t next_rx;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_parser(in_message_byte, in_final_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          next_rx = rx_pending.pop_front();
          in_valid        <= 1'b1;
          in_message_byte <= next_rx.data;
          in_final_byte   <= next_rx.last;
          if (in_bursts && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result of kind %0d with nothing awaited", out_item_kind);
          error_count++;
        end else begin
          want = awaited.pop_front();
          check_field("item_kind", want.item_kind, out_item_kind);
          check_field("value_byte", want.value_byte, out_value_byte);
          check_field("outcome", want.outcome, out_outcome);
          check_field("found_tag", want.found_tag, out_found_tag);
          check_field("found_length", want.found_length, out_found_length);
          check_field("counter_value", want.counter_value, out_counter_value);
          check_field("run_end", want.run_end, out_run_end);
          if (want.item_kind == KIND_STATUS) begin
            status_items++;
            outcome_seen[want.outcome]++;
          end else begin
            value_items++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_bursts && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 11);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OID_LENGTH: tgt.oid_length = val[4:0];
      CFG_OID_HEAD:   tgt.oid_head   = val;
      CFG_OID_TAIL:   tgt.oid_tail   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_target(input logic [4:0] len, input logic [63:0] head,
                            input logic [63:0] tail);
    write_reg(CFG_OID_LENGTH, {59'd0, len});
    write_reg(CFG_OID_HEAD, head);
    write_reg(CFG_OID_TAIL, tail);
  endtask

  task automatic settle();
    do @(negedge clk); while (rx_pending.size() != 0 || in_valid || awaited.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_len(input int n);
    int form;
    form = $urandom_range(0, 4);
    if (n == 0 && form == 4) begin
      frame.push_back(LEN_LONG_MIN);
    end else if (n < 128 && form < 2) begin
      frame.push_back(8'(n));
    end else if (n < 256 && form == 2) begin
      frame.push_back(LEN_LONG_MIN | 8'd1);
      frame.push_back(8'(n));
    end else if (form == 3) begin
      frame.push_back(LEN_LONG_MIN | 8'd4);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(8'(n >> 8));
      frame.push_back(8'(n));
    end else begin
      frame.push_back(LEN_LONG_MIN | 8'd2);
      frame.push_back(8'(n >> 8));
      frame.push_back(8'(n));
    end
  endtask

  task automatic put_tag(input logic [7:0] t);
    tag_spots.push_back(frame.size());
    frame.push_back(t);
  endtask

  task automatic put_field(input int n);
    put_len(n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  task automatic build_frame(input bit oversize);
    int n;
    int bad_at;
    logic [7:0] b;
    frame.delete();
    tag_spots.delete();
    put_tag(TAG_SEQUENCE);
    put_len($urandom_range(0, 400));
    put_tag(TAG_INTEGER);
    put_field($urandom_range(0, 3));
    put_tag(TAG_OCTETS);
    put_field(oversize ? 500 : $urandom_range(0, 10));
    frame.push_back(8'($urandom));
    put_len($urandom_range(0, 300));
    repeat (3) begin
      put_tag(TAG_INTEGER);
      put_field($urandom_range(0, 4));
    end
    put_tag(TAG_SEQUENCE);
    put_len($urandom_range(0, 200));
    put_tag(TAG_SEQUENCE);
    put_len($urandom_range(0, 200));
    put_tag(TAG_OID);
    n = ($urandom_range(0, 3) != 0) ? int'(tgt.oid_length) : $urandom_range(0, 18);
    bad_at = (n > 0 && $urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
    put_len(n);
    for (int i = 0; i < n; i++) begin
      b = (i < MAX_OID_BYTES) ? target_octet(4'(i)) : 8'($urandom);
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      frame.push_back(b);
    end
    frame.push_back(8'($urandom));
    if ($urandom_range(0, 11) == 0) begin
      frame.push_back(LEN_LONG_MIN | 8'd3);
      frame.push_back(8'h01);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      n = $urandom_range(1, 4);
    end else begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      put_len(n);
    end
    value_hdr_end = frame.size() - 1;
    repeat (n) frame.push_back(8'($urandom));
    value_end = frame.size() - 1;
    repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
  endtask

  task automatic queue_frame(input int cut);
    rx_byte_t e;
    for (int i = 0; i <= cut; i++) begin
      e.data = frame[i];
      e.last = (i == cut);
      rx_pending.push_back(e);
    end
    frames_sent++;
  endtask

  task automatic run_phase(input int budget, input bit oversize);
    int used;
    int count;
    int cut;
    int p;
    frame_shape_t shape;
    used  = 0;
    count = 0;
    while (used < budget) begin
      build_frame(oversize);
      if (oversize) shape = FR_WHOLE;
      else if (count < 5) shape = frame_shape_t'(count);
      else begin
        p = $urandom_range(0, 99);
        shape = (p < 60) ? FR_WHOLE : (p < 72) ? FR_CUT : (p < 82) ? FR_BAD_TAG :
                (p < 92) ? FR_SHORT_VALUE : FR_NOISE;
      end
      oversize = 1'b0;
      count++;
      case (shape)
        FR_WHOLE: cut = frame.size() - 1;
        FR_CUT:   cut = $urandom_range(0, frame.size() - 1);
        FR_BAD_TAG: begin
          p = tag_spots[$urandom_range(0, tag_spots.size() - 1)];
          frame[p] = frame[p] ^ 8'($urandom_range(1, 255));
          cut = frame.size() - 1;
        end
        FR_SHORT_VALUE: begin
          cut = (value_end > value_hdr_end) ? $urandom_range(value_hdr_end, value_end - 1)
                                            : frame.size() - 1;
        end
        default: begin
          frame.delete();
          repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
          cut = frame.size() - 1;
        end
      endcase
      queue_frame(cut);
      if (shape != FR_NOISE) used += cut + 1;
    end
  endtask

  initial begin
    clear_parse();
    tgt = '{oid_length: 5'd8, oid_head: 64'd0, oid_tail: 64'd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // bad first tag alone, then a complete frame with empty fields, a zero-length OID and a one-byte value
    set_target(5'd0, '1, '0);
    frame = '{8'h00};
    queue_frame(0);
    frame = '{TAG_SEQUENCE, LEN_LONG_MIN, TAG_INTEGER, 8'h00, TAG_OCTETS, 8'h00,
              8'hA2, 8'h00, TAG_INTEGER, 8'h00, TAG_INTEGER, 8'h00, TAG_INTEGER, 8'h00,
              TAG_SEQUENCE, 8'h00, TAG_SEQUENCE, 8'h00, TAG_OID, 8'h00,
              8'h41, 8'h01, 8'hFF};
    queue_frame(frame.size() - 1);
    settle();

    set_target(5'd8, {$urandom, $urandom}, {$urandom, $urandom});
    in_bursts  = 1'b1;
    out_bursts = 1'b1;
    run_phase(600, 1'b1);
    settle();

    set_target(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
    out_bursts = 1'b0;
    run_phase(180, 1'b0);
    settle();

    set_target(5'($urandom_range(1, 15)), '0, '1);
    in_bursts  = 1'b0;
    out_bursts = 1'b1;
    run_phase(140, 1'b0);
    settle();

    set_target(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
    in_bursts = 1'b1;
    run_phase(70, 1'b0);
    settle();

    set_target(5'($urandom_range(1, 16)), {$urandom, $urandom}, {$urandom, $urandom});
    in_bursts  = 1'b0;
    out_bursts = 1'b0;
    run_phase(180, 1'b0);
    settle();

    $display("Checked %0d value bytes and %0d status items from %0d frames (%0d bytes)",
             value_items, status_items, frames_sent, bytes_taken);
    $display("Outcomes: found %0d, bad tag %0d, truncated %0d, mismatch %0d, overrun %0d",
             outcome_seen[OC_FOUND], outcome_seen[OC_BAD_TAG], outcome_seen[OC_TRUNCATED],
             outcome_seen[OC_MISMATCH], outcome_seen[OC_OVERRUN]);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[ber_response_value_extractor_core.f]
src/brvx_pkg.sv
src/brvx_parser.sv
src/brvx_outq.sv
src/ber_response_value_extractor_core.sv
verif/ber_response_value_extractor_core_tb.sv
